>>> rtl/core/radix_digit_emitter_top_macros.svh
// Assertion helpers for the radix digit emitter.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef RADIX_DIGIT_EMITTER_TOP_MACROS_SVH
`define RADIX_DIGIT_EMITTER_TOP_MACROS_SVH

// Same-cycle implication
`define RDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rde_pkg.sv
`default_nettype none

package rde_pkg;

  // Alphabet and value geometry
  localparam int unsigned MAX_RADIX       = 16;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned DIGIT_W         = $clog2(MAX_RADIX);
  localparam int unsigned RADIX_W         = $clog2(MAX_RADIX + 1);
  localparam int unsigned ALPHA_REG_W     = 64;
  localparam int unsigned ALPHA_W         = 2 * ALPHA_REG_W;

  // Magnitude fits in VAL_W bits (-2^31 gives 2^31), so radix 2 needs VAL_W digits
  localparam int unsigned MAX_DIGITS      = VAL_W;
  localparam int unsigned DCNT_W          = $clog2(MAX_DIGITS + 1);

  // Divider takes one byte of the dividend per cycle
  localparam int unsigned STEP_BITS       = 8;
  localparam int unsigned STEPS_PER_DIGIT = VAL_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

  // Configuration port
  localparam int unsigned CFG_ADDR_W      = 4;
  localparam int unsigned CFG_DATA_W      = ALPHA_REG_W;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [ALPHA_W-1:0] alpha_t;

  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;

  localparam logic [ALPHA_REG_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_REG_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;

  // Register map, 8-byte stride: index is paddr[3]
  typedef enum logic {
    REG_ALPHA_LOW  = 1'b0,
    REG_ALPHA_HIGH = 1'b1
  } reg_idx_e;

  // One alphabet character by its digit index
  function automatic char_t alpha_byte(alpha_t tbl, digit_t idx);
    return tbl[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/radix_digit_emitter_top.sv
`default_nettype none
`include "radix_digit_emitter_top_macros.svh"

// Signed 32-bit integer to text in a radix set by a programmable alphabet of up
// to 16 characters (alphabet_low at byte address 0, alphabet_high at 8; the
// radix is the count of bytes before the first zero). A '-' leads negative
// values, digits follow most significant first, and tlast marks the last
// character. An alphabet shorter than two, holding '+' or '-', or with a
// repeated character makes the item produce no output. Each item is first
// accepted and its alphabet checked, then each digit comes from the shared
// divide unit, which retires one byte of the dividend per cycle, and then
// the characters go out as the sink takes them. tready is high only between
// items; the next item can be taken while the last character still waits in
// the output register.
module radix_digit_emitter_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input stream, tdata: value[31:0] (signed)
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  signed [rde_pkg::VAL_W-1:0]    s_axis_tdata,
  // Output stream, tdata: character[7:0]; tlast: final_char
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic        [rde_pkg::CHAR_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,
  // Configuration
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire         [rde_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire         [rde_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [rde_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  import rde_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Radix: position of first zero byte, else MAX_RADIX
  function automatic radix_t alpha_radix(alpha_t tbl);
    radix_t r;
    r = RADIX_W'(MAX_RADIX);
    for (int i = MAX_RADIX - 1; i >= 0; i--) begin
      if (alpha_byte(tbl, DIGIT_W'(i)) == '0) r = RADIX_W'(i);
    end
    return r;
  endfunction

  // Alphabet usable: long enough, no sign characters, no repeats
  function automatic logic alpha_ok(alpha_t tbl, radix_t radix);
    logic  ok;
    char_t ci;
    ok = (radix >= RADIX_W'(2));
    for (int i = 0; i < MAX_RADIX; i++) begin
      ci = alpha_byte(tbl, DIGIT_W'(i));
      if (RADIX_W'(i) < radix) begin
        if (ci == CHAR_PLUS || ci == CHAR_MINUS) ok = 1'b0;
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < radix && alpha_byte(tbl, DIGIT_W'(j)) == ci) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // Shared divide unit: restoring division of one dividend byte by the radix
  function automatic logic [DIGIT_W+STEP_BITS-1:0] div_step(digit_t rem_in,
                                                          logic [STEP_BITS-1:0] bits,
                                                          radix_t radix);
    logic [DIGIT_W:0]      t;
    digit_t                rem;
    logic [STEP_BITS-1:0]  q;
    rem = rem_in;
    q   = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      t = {rem, bits[k]};
      if (t >= radix) begin
        t    = t - radix;
        q[k] = 1'b1;
      end
      rem = t[DIGIT_W-1:0];
    end
    return {rem, q};
  endfunction

  state_e                           state_q, state_d;
  logic [ALPHA_REG_W-1:0]           alpha_low_q, alpha_low_d;
  logic [ALPHA_REG_W-1:0]           alpha_high_q, alpha_high_d;
  radix_t                           radix_q, radix_d;
  logic                             neg_q, neg_d;
  logic [DCNT_W-1:0]                dcnt_q, dcnt_d;
  logic [STEP_CNT_W-1:0]            step_q, step_d;
  logic                             out_valid_q, out_valid_d;
  char_t                            out_char_q, out_char_d;
  logic                             out_last_q, out_last_d;

  logic [VAL_W-1:0]                 mag_q, mag_d;
  digit_t                           rem_q, rem_d;
  digit_t                           stk_q [MAX_DIGITS];
  digit_t                           stk_d [MAX_DIGITS];

  alpha_t                           tbl;
  radix_t                           radix_w;
  logic [VAL_W-1:0]                 val_u;
  logic [DIGIT_W+STEP_BITS-1:0]     div_res;
  logic                             out_free;
  logic                             out_load;
  logic                             cfg_wr;

  assign tbl      = {alpha_high_q, alpha_low_q};
  assign radix_w  = alpha_radix(tbl);
  assign val_u    = s_axis_tdata;
  assign div_res  = div_step(rem_q, mag_q[VAL_W-1 -: STEP_BITS], radix_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign cfg_wr   = psel && penable && pwrite;

  // Register read-back
  always_comb begin
    unique case (reg_idx_e'(paddr[3]))
      REG_ALPHA_LOW:  prdata = alpha_low_q;
      REG_ALPHA_HIGH: prdata = alpha_high_q;
      default:        prdata = alpha_low_q;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    alpha_low_d  = alpha_low_q;
    alpha_high_d = alpha_high_q;
    radix_d      = radix_q;
    neg_d        = neg_q;
    dcnt_d       = dcnt_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    mag_d        = mag_q;
    rem_d        = rem_q;
    stk_d        = stk_q;
    out_load     = 1'b0;

    // Configuration writes
    if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3]))
        REG_ALPHA_LOW:  alpha_low_d  = pwdata;
        REG_ALPHA_HIGH: alpha_high_d = pwdata;
        default:        alpha_low_d  = alpha_low_q;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          neg_d   = val_u[VAL_W-1];
          mag_d   = val_u[VAL_W-1] ? (~val_u + 1'b1) : val_u;
          dcnt_d  = '0;
          step_d  = '0;
          rem_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        radix_d = radix_w;
        state_d = alpha_ok(tbl, radix_w) ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        // one dividend byte per cycle, quotient shifts in at the bottom
        mag_d  = {mag_q[VAL_W-STEP_BITS-1:0], div_res[STEP_BITS-1:0]};
        rem_d  = div_res[DIGIT_W+STEP_BITS-1 -: DIGIT_W];
        step_d = step_q + 1'b1;
        if (step_q == STEP_CNT_W'(STEPS_PER_DIGIT - 1)) begin
          // digit done: push remainder, later digits land on top
          stk_d[0] = div_res[DIGIT_W+STEP_BITS-1 -: DIGIT_W];
          for (int i = 1; i < MAX_DIGITS; i++) stk_d[i] = stk_q[i-1];
          dcnt_d = dcnt_q + 1'b1;
          rem_d  = '0;
          if (mag_d == '0) state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = alpha_byte(tbl, stk_q[0]);
          out_last_d  = (dcnt_q == DCNT_W'(1));
          for (int i = 0; i < MAX_DIGITS - 1; i++) stk_d[i] = stk_q[i+1];
          stk_d[MAX_DIGITS-1] = '0;
          dcnt_d = dcnt_q - 1'b1;
          if (dcnt_q == DCNT_W'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      alpha_low_q  <= ALPHA_LOW_RST;
      alpha_high_q <= ALPHA_HIGH_RST;
      radix_q      <= '0;
      neg_q        <= 1'b0;
      dcnt_q       <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      alpha_low_q  <= alpha_low_d;
      alpha_high_q <= alpha_high_d;
      radix_q      <= radix_d;
      neg_q        <= neg_d;
      dcnt_q       <= dcnt_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
      out_char_q   <= out_char_d;
      out_last_q   <= out_last_d;
    end
  end

  // Dividend, remainder and digit stack
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    stk_q <= stk_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign pready        = 1'b1;

  // Checks
  `RDE_ASSERT_NOW(a_rem_below_radix, state_q == ST_DIV, RADIX_W'(rem_q) < radix_q, "remainder reached radix")
  `RDE_ASSERT_NOW(a_stack_room, state_q == ST_DIV, dcnt_q < DCNT_W'(MAX_DIGITS), "digit stack overflow")
  `RDE_ASSERT_NOW(a_emit_nonempty, state_q == ST_EMIT, dcnt_q != '0, "emitting from empty stack")
  `RDE_ASSERT_NEXT(a_last_ends_item, out_load && out_last_d, state_q == ST_IDLE, "item not closed after last character")

endmodule

`default_nettype wire
